[rtl/core/conserved_to_primitive_ideal_gas_core_assert.svh]
`ifndef CONSERVED_TO_PRIMITIVE_IDEAL_GAS_CORE_ASSERT_SVH
`define CONSERVED_TO_PRIMITIVE_IDEAL_GAS_CORE_ASSERT_SVH

// implication checked at every edge, off while reset is held
`define CPIG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked at the edge after the antecedent
`define CPIG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/cpig_pkg.sv]
package cpig_pkg;
	localparam int Lanes = 4;
	localparam int EkinLane = 3;
	localparam int DivSteps = 32;
	localparam int FractionBitsDefault = 16;
	localparam int GammaWidth = 19;
	localparam logic [GammaWidth-1:0] GammaReset = 19'd91750;
	localparam int GammaShift = 16;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] acc;
	} lane_t;

	typedef struct packed {
		lane_t [Lanes-1:0] lane;
		logic [30:0] rho;
		logic [2:0] neg;
		logic [Lanes-1:0] ovf;
		logic signed [31:0] etot;
		logic bad;
	} div_word_t;
endpackage

[rtl/core/cpig_div_step.sv]
module cpig_div_step (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input cpig_pkg::div_word_t in_word,
	output logic out_valid,
	output cpig_pkg::div_word_t out_word
);
	import cpig_pkg::*;

	div_word_t nxt;
	logic valid_s1;
	div_word_t word_s1;

	always_comb begin
		logic [31:0] d;
		logic [32:0] t;
		logic ge;
		nxt = in_word;
		for (int i = 0; i < Lanes; i++) begin
			d = (i == EkinLane) ? {in_word.rho, 1'b0} : {1'b0, in_word.rho};
			t = {in_word.lane[i].rem, in_word.lane[i].acc[31]};
			ge = t >= {1'b0, d};
			nxt.lane[i].rem = ge ? 32'(t - {1'b0, d}) : t[31:0];
			nxt.lane[i].acc = {in_word.lane[i].acc[30:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_word = word_s1;
endmodule

[rtl/core/conserved_to_primitive_ideal_gas_core.sv]
// Converts one grid cell of conserved variables (density, momentum, total energy, signed
// fixed point) into velocity, internal energy and pressure for an ideal gas, with each result
// saturated to 32 bits. One word is accepted per cycle when the output side keeps taking
// results. A 32-step restoring divider runs the three velocity quotients and the kinetic
// energy quotient side by side, between preparation and result assembly registers. The
// whole pipeline holds while a result waits. A density of zero or below gives zero results
// and raises bad_density. The user writes the adiabatic index through cfg_we/cfg_wdata only
// while the pipeline is empty; the block itself does not enforce this.
module conserved_to_primitive_ideal_gas_core #(
	parameter int FRACTION_BITS = cpig_pkg::FractionBitsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [cpig_pkg::GammaWidth-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] density,
	input logic signed [31:0] momentum_x,
	input logic signed [31:0] momentum_y,
	input logic signed [31:0] momentum_z,
	input logic signed [31:0] total_energy,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] pressure,
	output logic signed [31:0] velocity_x,
	output logic signed [31:0] velocity_y,
	output logic signed [31:0] velocity_z,
	output logic signed [31:0] internal_energy,
	output logic bad_density,
	output logic saturated
);
	import cpig_pkg::*;
	`include "conserved_to_primitive_ideal_gas_core_assert.svh"

	logic en;
	logic [GammaWidth-1:0] gamma_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [31:0] rho_s1, etot_s1;
	logic signed [31:0] mom_s1 [3];

	logic [31:0] am_s2 [3];
	logic [63:0] sq_s2 [3];
	logic [2:0] neg_s2;
	logic [30:0] rho_s2;
	logic signed [31:0] etot_s2;
	logic bad_s2;

	div_word_t word_s3;
	div_word_t dw [DivSteps+1];
	logic dv [DivSteps+1];

	logic signed [31:0] vel_s4 [3];
	logic signed [31:0] eint_s4;
	logic clip_s4, bad_s4;

	logic signed [31:0] vel_s5 [3];
	logic signed [31:0] eint_s5;
	logic signed [52:0] prod_s5;
	logic clip_s5, bad_s5;

	logic signed [31:0] p_s6, eint_s6;
	logic signed [31:0] vel_s6 [3];
	logic clip_s6, bad_s6;

	assign en = !v_s6 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GammaReset;
		end else if (cfg_we) begin
			gamma_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv[DivSteps];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en) begin
			rho_s1 <= density;
			etot_s1 <= total_energy;
			mom_s1[0] <= momentum_x;
			mom_s1[1] <= momentum_y;
			mom_s1[2] <= momentum_z;
		end
	end

	// magnitudes and squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				logic [31:0] a;
				a = mom_s1[c][31] ? 32'(-mom_s1[c]) : 32'(mom_s1[c]);
				am_s2[c] <= a;
				sq_s2[c] <= 64'(a) * 64'(a);
				neg_s2[c] <= mom_s1[c][31];
			end
			rho_s2 <= rho_s1[30:0];
			etot_s2 <= etot_s1;
			bad_s2 <= rho_s1 <= 32'sd0;
		end
	end

	// divider setup: high half as starting remainder, overflow when quotient needs more than 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			logic [63:0] num;
			logic [63:0] ssum;
			for (int c = 0; c < 3; c++) begin
				num = 64'(am_s2[c]) << FRACTION_BITS;
				word_s3.lane[c].rem <= num[63:32];
				word_s3.lane[c].acc <= num[31:0];
				word_s3.ovf[c] <= num[63:32] >= {1'b0, rho_s2};
			end
			ssum = sq_s2[0] + sq_s2[1] + sq_s2[2];
			word_s3.lane[EkinLane].rem <= ssum[63:32];
			word_s3.lane[EkinLane].acc <= ssum[31:0];
			word_s3.ovf[EkinLane] <= ssum[63:32] >= {rho_s2, 1'b0};
			word_s3.rho <= rho_s2;
			word_s3.neg <= neg_s2;
			word_s3.etot <= etot_s2;
			word_s3.bad <= bad_s2;
		end
	end

	assign dw[0] = word_s3;
	assign dv[0] = v_s3;

	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		cpig_div_step u_step (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(dv[k]),
			.in_word(dw[k]),
			.out_valid(dv[k+1]),
			.out_word(dw[k+1])
		);
	end

	// signs, saturation, internal energy
	always_ff @(posedge clk) begin
		if (en) begin
			logic clip;
			logic [31:0] q;
			logic signed [33:0] e;
			logic signed [31:0] vel [3];
			logic signed [31:0] eint;
			div_word_t w;
			w = dw[DivSteps];
			clip = 1'b0;
			for (int c = 0; c < 3; c++) begin
				q = w.lane[c].acc;
				if (!w.neg[c]) begin
					if (w.ovf[c] || q > 32'h7fff_ffff) begin
						vel[c] = 32'sh7fff_ffff;
						clip = 1'b1;
					end else begin
						vel[c] = $signed(q);
					end
				end else begin
					if (w.ovf[c] || q > 32'h8000_0000) begin
						vel[c] = 32'sh8000_0000;
						clip = 1'b1;
					end else begin
						vel[c] = $signed(32'(-q));
					end
				end
			end
			e = 34'(w.etot) - $signed({2'b00, w.lane[EkinLane].acc});
			if (w.ovf[EkinLane]) begin
				eint = 32'sh8000_0000;
				clip = 1'b1;
			end else if (e[33:31] != 3'b000 && e[33:31] != 3'b111) begin
				eint = e[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				clip = 1'b1;
			end else begin
				eint = e[31:0];
			end
			if (w.bad) begin
				for (int c = 0; c < 3; c++) begin
					vel[c] = 32'sd0;
				end
				eint = 32'sd0;
				clip = 1'b0;
			end
			vel_s4 <= vel;
			eint_s4 <= eint;
			clip_s4 <= clip;
			bad_s4 <= w.bad;
		end
	end

	// (gamma - 1) times internal energy
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [20:0] gm1;
			gm1 = $signed({2'b00, gamma_q}) - 21'sd65536;
			prod_s5 <= 53'(gm1) * 53'(eint_s4);
			vel_s5 <= vel_s4;
			eint_s5 <= eint_s4;
			clip_s5 <= clip_s4;
			bad_s5 <= bad_s4;
		end
	end

	// floor shift and saturation of pressure
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [36:0] p;
			p = prod_s5[52:GammaShift];
			if (p[36:31] != 6'b000000 && p[36:31] != 6'b111111) begin
				p_s6 <= p[36] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				clip_s6 <= 1'b1;
			end else begin
				p_s6 <= p[31:0];
				clip_s6 <= clip_s5;
			end
			vel_s6 <= vel_s5;
			eint_s6 <= eint_s5;
			bad_s6 <= bad_s5;
		end
	end

	assign out_valid = v_s6;
	assign pressure = p_s6;
	assign velocity_x = vel_s6[0];
	assign velocity_y = vel_s6[1];
	assign velocity_z = vel_s6[2];
	assign internal_energy = eint_s6;
	assign bad_density = bad_s6;
	assign saturated = clip_s6;

	`CPIG_ASSERT_IMP(a_bad_zero, out_valid && bad_density, pressure == 32'sd0 && internal_energy == 32'sd0 && !saturated, "bad density word carries nonzero result")
	`CPIG_ASSERT_IMP(a_hold, out_valid && !out_ready, !in_ready, "input taken while output stalled")
	`CPIG_ASSERT_IMP(a_rem_ekin, dv[DivSteps] && !dw[DivSteps].bad && !dw[DivSteps].ovf[EkinLane], dw[DivSteps].lane[EkinLane].rem < {dw[DivSteps].rho, 1'b0}, "kinetic energy remainder out of range")
	`CPIG_ASSERT_NEXT(a_stall_keep, out_valid && !out_ready, out_valid && $stable(pressure), "stalled word changed")
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import cpig_pkg::*;

	localparam int FB = 16;
	localparam int Latency = 38;
	localparam int WatchdogLimit = 20000;
	localparam int NumRandom = 1100;

	typedef struct packed {
		logic signed [31:0] rho;
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic signed [31:0] mz;
		logic signed [31:0] etot;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] p;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] eint;
		logic bad;
		logic sat;
	} prim_t;

	typedef struct {
		cell_t c;
		logic has_exp;
		prim_t e;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [GammaWidth-1:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] density = 0, momentum_x = 0, momentum_y = 0, momentum_z = 0;
	logic signed [31:0] total_energy = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] pressure, velocity_x, velocity_y, velocity_z, internal_energy;
	logic bad_density, saturated;

	conserved_to_primitive_ideal_gas_core #(.FRACTION_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .density(density),
		.momentum_x(momentum_x), .momentum_y(momentum_y), .momentum_z(momentum_z),
		.total_energy(total_energy), .out_valid(out_valid), .out_ready(out_ready),
		.pressure(pressure), .velocity_x(velocity_x), .velocity_y(velocity_y),
		.velocity_z(velocity_z), .internal_energy(internal_energy),
		.bad_density(bad_density), .saturated(saturated)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	logic [GammaWidth-1:0] gamma_q = GammaReset;
	prim_t pending_prims[$];
	int errors = 0;
	int idle_cycles = 0;
	int in_idle_pct = 34;
	int out_idle_pct = 34;
	int hold_off = 0;

	function automatic logic signed [31:0] clip32(input logic signed [127:0] v, inout logic sat);
		if (v > 128'sd2147483647) begin
			sat = 1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			sat = 1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic prim_t to_primitive(input cell_t c);
		prim_t r;
		logic signed [127:0] rho, q, s, ek, e, gm1, prod, pv;
		logic sat;
		r = '0;
		sat = 0;
		if (c.rho <= 0) begin
			r.bad = 1;
			return r;
		end
		rho = c.rho;
		q = (128'(signed'(c.mx)) <<< FB) / rho;
		r.vx = clip32(q, sat);
		q = (128'(signed'(c.my)) <<< FB) / rho;
		r.vy = clip32(q, sat);
		q = (128'(signed'(c.mz)) <<< FB) / rho;
		r.vz = clip32(q, sat);
		s = 128'(signed'(c.mx)) * c.mx + 128'(signed'(c.my)) * c.my
			+ 128'(signed'(c.mz)) * c.mz;
		ek = s / (rho * 2);
		e = 128'(signed'(c.etot)) - ek;
		r.eint = clip32(e, sat);
		gm1 = 128'(signed'({1'b0, gamma_q})) - 65536;
		prod = gm1 * r.eint;
		if (prod >= 0)
			pv = prod >>> GammaShift;
		else
			pv = -((-prod + 65535) >>> GammaShift);
		r.p = clip32(pv, sat);
		r.sat = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready)
			idle_cycles <= 0;
		else if (!(out_valid && out_ready))
			idle_cycles <= idle_cycles + 1;
		else
			idle_cycles <= 0;
		if (idle_cycles > WatchdogLimit) begin
			$display("conserved_to_primitive_ideal_gas_core verification failed");
			$finish;
		end
	end

	// receiver side
	always @(posedge clk) begin
		prim_t x;
		if (arst_n && out_valid && out_ready) begin
			if (pending_prims.size() == 0) begin
				report_mismatch("unexpected word", 32'd0, 32'd0);
			end else begin
				x = pending_prims.pop_front();
				if (pressure !== x.p) report_mismatch("pressure", pressure, x.p);
				if (velocity_x !== x.vx) report_mismatch("velocity_x", velocity_x, x.vx);
				if (velocity_y !== x.vy) report_mismatch("velocity_y", velocity_y, x.vy);
				if (velocity_z !== x.vz) report_mismatch("velocity_z", velocity_z, x.vz);
				if (internal_energy !== x.eint)
					report_mismatch("internal_energy", internal_energy, x.eint);
				if (bad_density !== x.bad)
					report_mismatch("bad_density", 32'(bad_density), 32'(x.bad));
				if (saturated !== x.sat)
					report_mismatch("saturated", 32'(saturated), 32'(x.sat));
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 0;
		end else begin
			out_ready <= arst_n && ($urandom_range(99) >= out_idle_pct);
		end
	end

	task automatic send_cell(input cell_t c, input logic has_exp, input prim_t want);
		prim_t p;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		p = to_primitive(c);
		if (has_exp && p !== want) begin
			$display("table row disagrees with predictor for cell %h", c);
			errors++;
		end
		pending_prims.push_back(p);
		in_valid <= 1;
		density <= c.rho;
		momentum_x <= c.mx;
		momentum_y <= c.my;
		momentum_z <= c.mz;
		total_energy <= c.etot;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_prims.size() != 0)
			@(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic set_gamma(input logic [GammaWidth-1:0] g);
		drain();
		cfg_we <= 1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 0;
		gamma_q = g;
	endtask

	function automatic logic signed [31:0] rnd_field();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 1) ? $urandom_range(0, 511) : -$urandom_range(0, 511);
			3: return $signed($urandom) >>> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic cell_t rnd_cell();
		cell_t c;
		c.rho = rnd_field();
		if ($urandom_range(9) != 0 && c.rho <= 0)
			c.rho = $urandom_range(1, 32'h7fffffff);
		c.mx = rnd_field();
		c.my = rnd_field();
		c.mz = rnd_field();
		c.etot = rnd_field();
		return c;
	endfunction

	row_t stim_table[$];

	initial begin
		prim_t z, badp;
		cell_t c;
		logic [GammaWidth-1:0] gammas[6];
		int i;
		z = '0;
		badp = '0;
		badp.bad = 1;
		// zero/negative density, unit cells, extremes
		stim_table.push_back('{'{0, 5, 6, 7, 8}, 1, badp});
		stim_table.push_back('{'{32'sh80000000, 32'sh7fffffff, 1, 1, 1}, 1, badp});
		stim_table.push_back('{'{-1, 0, 0, 0, 0}, 1, badp});
		stim_table.push_back('{'{32'sh10000, 0, 0, 0, 0}, 1, z});
		stim_table.push_back('{'{32'sh10000, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh100000},
			0, z});
		stim_table.push_back('{'{1, 32'sh7fffffff, 32'sh80000000, 1, 0}, 0, z});
		stim_table.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff}, 0, z});
		stim_table.push_back('{'{32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000}, 0, z});
		stim_table.push_back('{'{1, 0, 0, 0, 32'sh7fffffff}, 0, z});
		stim_table.push_back('{'{1, 0, 0, 0, 32'sh80000000}, 0, z});
		stim_table.push_back('{'{32'sh10000, -1, 1, -1, -32'sh10000}, 0, z});
		stim_table.push_back('{'{3, -7, 7, 5, 1}, 0, z});

		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (stim_table[k])
			send_cell(stim_table[k].c, stim_table[k].has_exp, stim_table[k].e);

		gammas = '{19'd0, 19'd65536, 19'd262144, 19'h7ffff, 19'd65535, GammaReset};
		for (int g = 0; g < 6; g++) begin
			set_gamma(gammas[g]);
			for (i = 0; i < 6; i++)
				send_cell(stim_table[3 + i].c, 0, z);
		end

		// random, with a stretch without idles, a long receiver hold-off and a sender pause
		for (i = 0; i < NumRandom; i++) begin
			if (i % 220 == 0 && i != 0)
				set_gamma(GammaWidth'($urandom_range(0, 19'h7ffff)));
			if (i == 300) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			if (i == 450) begin
				in_idle_pct = 34;
				out_idle_pct = 34;
				hold_off = 200;
			end
			if (i == 700)
				drain();
			c = rnd_cell();
			send_cell(c, 0, z);
		end

		drain();
		if (errors == 0)
			$display("conserved_to_primitive_ideal_gas_core verification clean");
		else
			$display("conserved_to_primitive_ideal_gas_core verification failed");
		$finish;
	end
endmodule

`default_nettype wire
